// ===== rtl/cpc_pkg.sv =====
// Shared constants, types and ROM contents of the cosine palette colorizer.
`timescale 1ns / 1ps

package cpc_pkg;

  localparam int unsigned ROM_INDEX_BITS = 10;
  localparam int unsigned COORD_BITS     = 12;
  localparam int unsigned ROM_DEPTH      = 1 << ROM_INDEX_BITS;

  localparam int unsigned ITER_BITS  = 16;
  localparam int unsigned INV_BITS   = 25;
  localparam int unsigned COLOR_BITS = 32;
  localparam int unsigned PHASE_BITS = 16;
  localparam int unsigned SHIFT_BITS = 33;
  localparam int unsigned PROD_BITS  = ITER_BITS + INV_BITS;
  localparam int unsigned NORM_DROP  = 8;

  localparam logic [SHIFT_BITS-1:0] SHIFT_STEP = SHIFT_BITS'(429);
  localparam logic [SHIFT_BITS-1:0] SHIFT_TURN = SHIFT_BITS'(64'h1_0000_0000);

  // Stream word sizes, packed without gaps and padded to whole bytes
  localparam int unsigned IN_FIELD_BITS  = 2 * COORD_BITS + ITER_BITS;
  localparam int unsigned IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
  localparam int unsigned OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Register file
  localparam int unsigned ADDR_BITS    = 5;
  localparam int unsigned REG_IDX_BITS = ADDR_BITS - 2;
  localparam logic [REG_IDX_BITS-1:0] REG_ITER_LIMIT  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_INV_MAX     = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_INTERIOR    = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_PHASE_RED   = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_PHASE_GREEN = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_PHASE_BLUE  = 3'd5;

  localparam logic [ITER_BITS-1:0]  RST_ITER_LIMIT  = 16'd256;
  localparam logic [INV_BITS-1:0]   RST_INV_MAX     = 25'd65536;
  localparam logic [COLOR_BITS-1:0] RST_INTERIOR    = 32'd255;
  localparam logic [PHASE_BITS-1:0] RST_PHASE_RED   = 16'd18285;
  localparam logic [PHASE_BITS-1:0] RST_PHASE_GREEN = 16'd33227;
  localparam logic [PHASE_BITS-1:0] RST_PHASE_BLUE  = 16'd42402;

  typedef struct packed {
    logic [COLOR_BITS-1:0] color;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } out_word_t;

  typedef logic [15:0] pow_rom_t [ROM_DEPTH];
  typedef logic [7:0]  cos_rom_t [ROM_DEPTH];

  // floor(65536 * (k / depth)^0.4): largest y with y^5 <= k^2 * 2^(80 - 2*index bits)
  function automatic logic [15:0] pow_entry(int unsigned k);
    logic [127:0] lim;
    logic [127:0] p;
    logic [16:0]  lo;
    logic [16:0]  hi;
    logic [16:0]  y;
    lim = (128'(k) * 128'(k)) << (80 - 2 * ROM_INDEX_BITS);
    lo  = '0;
    hi  = 17'd65535;
    for (int i = 0; i < 17; i++) begin
      if (lo < hi) begin
        y = (lo + hi + 17'd1) >> 1;
        p = 128'(y) * 128'(y) * 128'(y) * 128'(y) * 128'(y);
        if (p <= lim) lo = y;
        else hi = y - 17'd1;
      end
    end
    return lo[15:0];
  endfunction

  // 255*(0.5+0.5cos), quadrant folded, Taylor series in Q2.30 truncated to x^14
  function automatic logic [7:0] cos_entry(int unsigned idx);
    longint unsigned q;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned m;
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    longint          h;
    q     = 64'd1 << (ROM_INDEX_BITS - 2);
    quad  = (64'(idx) >> (ROM_INDEX_BITS - 2)) & 64'd3;
    r     = 64'(idx) & (q - 64'd1);
    m     = quad[0] ? q - r : r;
    theta = (m * 64'd6746518852) >> ROM_INDEX_BITS;
    t2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    sum   = 64'sd1 << 30;
    for (int n = 1; n <= 7; n++) begin
      term = (term * t2) >> 30;
      case (n)
        1:       term = term / 64'd2;
        2:       term = term / 64'd12;
        3:       term = term / 64'd30;
        4:       term = term / 64'd56;
        5:       term = term / 64'd90;
        6:       term = term / 64'd132;
        default: term = term / 64'd182;
      endcase
      if (n % 2 == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (quad == 64'd1 || quad == 64'd2) h = (64'sd1 << 30) - sum;
    else h = (64'sd1 << 30) + sum;
    if (h < 0) h = 0;
    if (h > (64'sd1 << 31)) h = 64'sd1 << 31;
    v = (64'd255 * unsigned'(h)) >> 31;
    if (v > 64'd255) v = 64'd255;
    return v[7:0];
  endfunction

  function automatic pow_rom_t build_pow_rom();
    pow_rom_t t;
    for (int k = 0; k < ROM_DEPTH; k++) t[k] = pow_entry(k);
    return t;
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t t;
    for (int k = 0; k < ROM_DEPTH; k++) t[k] = cos_entry(k);
    return t;
  endfunction

  localparam pow_rom_t POW_ROM = build_pow_rom();
  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ===== rtl/cpc_pow_rom.sv =====
// Power-law ROM: registered read of d^0.4 in Q0.16.
`timescale 1ns / 1ps

module cpc_pow_rom
  import cpc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ROM_INDEX_BITS-1:0] addr_i,
  output logic [15:0]               data_o
);

  logic [15:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= POW_ROM[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/cpc_cos_rom.sv =====
// Cosine ROM: registered read of one 8-bit color channel level.
`timescale 1ns / 1ps

module cpc_cos_rom
  import cpc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ROM_INDEX_BITS-1:0] addr_i,
  output logic [7:0]                data_o
);

  logic [7:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= COS_ROM[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/cpc_skid.sv =====
// Output register with a skid slot; its ready is a flop, cutting the tready path.
`timescale 1ns / 1ps

module cpc_skid
  import cpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  out_word_t in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic      out_valid_q;
  logic      skid_valid_q;
  out_word_t out_word_q;
  out_word_t skid_word_q;
  logic      in_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) out_word_q <= skid_word_q;
      else if (in_fire) out_word_q <= in_word_i;
    end else if (in_fire) begin
      skid_word_q <= in_word_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a word while the output is empty");

  a_stall_parks_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && in_fire) |=> (skid_valid_q && out_valid_q))
    else $error("word taken during a stall was not parked");

endmodule

// ===== rtl/cosine_palette_colorizer.sv =====
// Cosine palette colorizer: iteration count to RGBA, one pixel per clock.
//
// Input stream (s_axis_*): one word per pixel with column, row and escape
// iteration count in tdata and the palette cycling key in tuser. Output
// stream (m_axis_*): column, row and packed RGBA color (red in the top byte,
// alpha 255 in the low byte). Interior pixels (count equal to the iteration
// limit) take interior_color. An APB port holds the six palette registers;
// write them only while no pixel is in flight.
// An accepted input word reaches m_axis through the input register, the
// power ROM read, the cosine ROM read and the output register.
// Throughput: one pixel per clock while the output buffer is not full, set
// by the combinational multiply and the one-port registered ROM reads.
// The cycling accumulator advances by 429 per accepted pixel whose key is
// held and wraps to zero past one full turn.
// Reset: registers return to their defaults, the accumulator clears, the
// pipeline empties. When the receiver stalls the pipeline advances into a
// two-entry output buffer; s_axis_tready_o drops only once both are full.
`timescale 1ns / 1ps

module cosine_palette_colorizer
  import cpc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // stream in
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,  // pixel_x, pixel_y, iteration_count
  input  logic                      s_axis_tuser_i,  // cycle_key
  // stream out
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o,  // out_x, out_y, pixel_color
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_BITS-1:0]      paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // Registers
  logic [ITER_BITS-1:0]  iter_limit_q;
  logic [INV_BITS-1:0]   inv_max_q;
  logic [COLOR_BITS-1:0] interior_q;
  logic [PHASE_BITS-1:0] phase_red_q;
  logic [PHASE_BITS-1:0] phase_green_q;
  logic [PHASE_BITS-1:0] phase_blue_q;
  logic                  cfg_wr;
  logic [REG_IDX_BITS-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_BITS-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_limit_q  <= RST_ITER_LIMIT;
      inv_max_q     <= RST_INV_MAX;
      interior_q    <= RST_INTERIOR;
      phase_red_q   <= RST_PHASE_RED;
      phase_green_q <= RST_PHASE_GREEN;
      phase_blue_q  <= RST_PHASE_BLUE;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ITER_LIMIT:  iter_limit_q  <= pwdata[ITER_BITS-1:0];
        REG_INV_MAX:     inv_max_q     <= pwdata[INV_BITS-1:0];
        REG_INTERIOR:    interior_q    <= pwdata[COLOR_BITS-1:0];
        REG_PHASE_RED:   phase_red_q   <= pwdata[PHASE_BITS-1:0];
        REG_PHASE_GREEN: phase_green_q <= pwdata[PHASE_BITS-1:0];
        REG_PHASE_BLUE:  phase_blue_q  <= pwdata[PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ITER_LIMIT:  prdata = 32'(iter_limit_q);
      REG_INV_MAX:     prdata = 32'(inv_max_q);
      REG_INTERIOR:    prdata = 32'(interior_q);
      REG_PHASE_RED:   prdata = 32'(phase_red_q);
      REG_PHASE_GREEN: prdata = 32'(phase_green_q);
      REG_PHASE_BLUE:  prdata = 32'(phase_blue_q);
      default:         prdata = '0;
    endcase
  end

  // Pipeline advance is the skid buffer's registered ready
  logic advance;
  logic accept;

  assign s_axis_tready_o = advance;
  assign accept          = s_axis_tvalid_i && advance;

  // Palette cycling accumulator; the pixel sees the advanced value
  logic [SHIFT_BITS-1:0] shift_q;
  logic [SHIFT_BITS-1:0] shift_d;
  logic [SHIFT_BITS-1:0] shift_sum;

  assign shift_sum = shift_q + SHIFT_STEP;

  always_comb begin
    shift_d = shift_q;
    if (accept && s_axis_tuser_i) begin
      shift_d = (shift_sum > SHIFT_TURN) ? '0 : shift_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) shift_q <= '0;
    else shift_q <= shift_d;
  end

  // Stage 1: input register
  logic                  v1_q;
  logic [COORD_BITS-1:0] x1_q;
  logic [COORD_BITS-1:0] y1_q;
  logic [ITER_BITS-1:0]  iter1_q;
  logic [15:0]           sh1_q;
  logic                  int1_q;

  // Stage 2: power ROM output
  logic                  v2_q;
  logic [COORD_BITS-1:0] x2_q;
  logic [COORD_BITS-1:0] y2_q;
  logic [15:0]           sh2_q;
  logic                  int2_q;
  logic [15:0]           pow_e;

  // Stage 3: cosine ROM outputs
  logic                  v3_q;
  logic [COORD_BITS-1:0] x3_q;
  logic [COORD_BITS-1:0] y3_q;
  logic                  int3_q;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x1_q    <= s_axis_tdata_i[COORD_BITS-1:0];
      y1_q    <= s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
      iter1_q <= s_axis_tdata_i[IN_FIELD_BITS-1:2*COORD_BITS];
      sh1_q   <= shift_d[31:16];
      int1_q  <= s_axis_tdata_i[IN_FIELD_BITS-1:2*COORD_BITS] == iter_limit_q;
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      sh2_q   <= sh1_q;
      int2_q  <= int1_q;
      x3_q    <= x2_q;
      y3_q    <= y2_q;
      int3_q  <= int2_q;
    end
  end

  // Normalize: d = iter * reciprocal, Q0.16 saturated below 1.0
  logic [PROD_BITS-1:0]           prod;
  logic [PROD_BITS-NORM_DROP-1:0] d_wide;
  logic [15:0]                    d_sat;

  assign prod   = PROD_BITS'(iter1_q) * PROD_BITS'(inv_max_q);
  assign d_wide = prod[PROD_BITS-1:NORM_DROP];
  assign d_sat  = (|d_wide[PROD_BITS-NORM_DROP-1:16]) ? 16'hFFFF : d_wide[15:0];

  cpc_pow_rom u_pow_rom (
    .clk_i  (clk_i),
    .en_i   (advance),
    .addr_i (d_sat[15 -: ROM_INDEX_BITS]),
    .data_o (pow_e)
  );

  // Phase per channel, upper half of the Q0.32 turn; low half never carries
  logic [15:0] phase_r;
  logic [15:0] phase_g;
  logic [15:0] phase_b;

  assign phase_r = pow_e + phase_red_q + sh2_q;
  assign phase_g = pow_e + phase_green_q + sh2_q;
  assign phase_b = pow_e + phase_blue_q + sh2_q;

  cpc_cos_rom u_cos_red (
    .clk_i  (clk_i),
    .en_i   (advance),
    .addr_i (phase_r[15 -: ROM_INDEX_BITS]),
    .data_o (red)
  );

  cpc_cos_rom u_cos_green (
    .clk_i  (clk_i),
    .en_i   (advance),
    .addr_i (phase_g[15 -: ROM_INDEX_BITS]),
    .data_o (green)
  );

  cpc_cos_rom u_cos_blue (
    .clk_i  (clk_i),
    .en_i   (advance),
    .addr_i (phase_b[15 -: ROM_INDEX_BITS]),
    .data_o (blue)
  );

  out_word_t result;
  out_word_t out_word;

  always_comb begin
    result.x     = x3_q;
    result.y     = y3_q;
    result.color = int3_q ? interior_q : {red, green, blue, 8'hFF};
  end

  cpc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_ready_o  (advance),
    .in_word_i   (result),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_word_o  (out_word)
  );

  assign m_axis_tdata_o = OUT_TDATA_BITS'(out_word);

  a_shift_in_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_q <= SHIFT_TURN)
    else $error("cycling accumulator passed one turn");

  a_stage1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && advance) |=> v2_q)
    else $error("pixel lost between input register and power ROM stage");

  a_stage2_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && advance) |=> v3_q)
    else $error("pixel lost between power ROM and cosine ROM stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !advance) |=> v3_q)
    else $error("pixel dropped from last stage while stalled");

endmodule

// ===== sim/cosine_palette_colorizer_test.sv =====
// Self-checking testbench of the cosine palette colorizer.
`timescale 1ns / 1ps

module cosine_palette_colorizer_test;
  import cpc_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_WORDS = 66;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
  } pixel_expect_t;

  // Directed word; typed marks a row whose color is written out below
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [ITER_BITS-1:0]  iter;
    logic                  key;
    logic                  typed;
    logic [COLOR_BITS-1:0] color;
  } pixel_probe_t;

  logic                      clk_i;
  logic                      rst_ni          = 1'b0;
  logic                      s_axis_tvalid_i = 1'b0;
  logic                      s_axis_tready_o;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i  = '0;  // pixel_x, pixel_y, iteration_count
  logic                      s_axis_tuser_i  = 1'b0;  // cycle_key
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i = 1'b1;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o;  // out_x, out_y, pixel_color
  logic                      psel            = 1'b0;
  logic                      penable         = 1'b0;
  logic                      pwrite          = 1'b0;
  logic [ADDR_BITS-1:0]      paddr           = '0;
  logic [31:0]               pwdata          = '0;
  logic [31:0]               prdata;
  logic                      pready;

  // Register mirror and cycling accumulator of the predictor
  logic [ITER_BITS-1:0]  pal_iter_limit = RST_ITER_LIMIT;
  logic [INV_BITS-1:0]   pal_inv_max    = RST_INV_MAX;
  logic [COLOR_BITS-1:0] pal_interior   = RST_INTERIOR;
  logic [PHASE_BITS-1:0] pal_phase_r    = RST_PHASE_RED;
  logic [PHASE_BITS-1:0] pal_phase_g    = RST_PHASE_GREEN;
  logic [PHASE_BITS-1:0] pal_phase_b    = RST_PHASE_BLUE;
  logic [SHIFT_BITS-1:0] turn_acc       = '0;

  logic [15:0] root_lut [ROM_DEPTH];
  logic [7:0]  wave_lut [ROM_DEPTH];

  pixel_expect_t color_expect_q [$];
  int unsigned   mismatch_count = 0;
  int unsigned   stall_cycles   = 0;
  int unsigned   idle_pct       = 0;
  int unsigned   stall_pct      = 0;

  pixel_probe_t probe_rows [16] = '{
    '{12'd0,   12'd0,   16'd0,     1'b0, 1'b0, 32'd0},
    '{12'hFFF, 12'hFFF, 16'hFFFF,  1'b0, 1'b0, 32'd0},  // d saturates
    '{12'd1,   12'd2,   16'd256,   1'b0, 1'b1, 32'h0000_00FF},  // interior
    '{12'd3,   12'd4,   16'd256,   1'b1, 1'b1, 32'h0000_00FF},  // interior, key held
    '{12'd5,   12'd6,   16'd255,   1'b1, 1'b0, 32'd0},
    '{12'd7,   12'd8,   16'd257,   1'b1, 1'b0, 32'd0},  // count above limit
    '{12'hAAA, 12'h555, 16'h5555,  1'b1, 1'b0, 32'd0},
    '{12'h555, 12'hAAA, 16'hAAAA,  1'b0, 1'b0, 32'd0},
    '{12'd9,   12'd10,  16'd1,     1'b1, 1'b0, 32'd0},
    '{12'd11,  12'd12,  16'd64,    1'b1, 1'b0, 32'd0},
    '{12'd13,  12'd14,  16'd128,   1'b0, 1'b0, 32'd0},
    '{12'd15,  12'd16,  16'd192,   1'b1, 1'b0, 32'd0},
    '{12'd17,  12'd18,  16'd255,   1'b0, 1'b0, 32'd0},
    '{12'hFFF, 12'd0,   16'd0,     1'b1, 1'b0, 32'd0},
    '{12'd0,   12'hFFF, 16'd256,   1'b0, 1'b1, 32'h0000_00FF},
    '{12'h800, 12'h800, 16'h8000,  1'b1, 1'b0, 32'd0}
  };

  cosine_palette_colorizer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fill the power and cosine lookup tables of the predictor
  initial begin
    logic [127:0]    lim;
    logic [127:0]    t;
    logic [15:0]     y;
    longint unsigned q;
    longint unsigned quad;
    longint unsigned m;
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    longint          h;
    q = 64'd1 << (ROM_INDEX_BITS - 2);
    for (int k = 0; k < ROM_DEPTH; k++) begin
      // largest y with y^5 <= k^2 * 2^(80 - 2*index bits), built bit by bit
      lim = (128'(k) * 128'(k)) << (80 - 2 * ROM_INDEX_BITS);
      y = '0;
      for (int b = 15; b >= 0; b--) begin
        t = 128'(y | (16'd1 << b));
        if (t * t * t * t * t <= lim) y = y | (16'd1 << b);
      end
      root_lut[k] = y;

      quad = (64'(k) >> (ROM_INDEX_BITS - 2)) & 64'd3;
      m = 64'(k) & (q - 64'd1);
      if (quad[0]) m = q - m;
      theta = (m * 64'd6746518852) >> ROM_INDEX_BITS;
      t2 = (theta * theta) >> 30;
      term = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (quad == 64'd1 || quad == 64'd2) h = (64'sd1 << 30) - sum;
      else h = (64'sd1 << 30) + sum;
      if (h < 0) h = 0;
      if (h > (64'sd1 << 31)) h = 64'sd1 << 31;
      v = (64'd255 * unsigned'(h)) >> 31;
      wave_lut[k] = (v > 64'd255) ? 8'hFF : v[7:0];
    end
  end

  function automatic logic [7:0] channel_level(input logic [15:0] root,
                                               input logic [PHASE_BITS-1:0] offset);
    logic [31:0] angle;
    angle = {root, 16'h0} + turn_acc[31:0] + {offset, 16'h0};
    return wave_lut[angle[31 -: ROM_INDEX_BITS]];
  endfunction

  function automatic logic [COLOR_BITS-1:0] shade_pixel(input logic [ITER_BITS-1:0] iter);
    logic [PROD_BITS-1:0] prod;
    logic [15:0]          frac;
    logic [15:0]          root;
    if (iter == pal_iter_limit) return pal_interior;
    prod = PROD_BITS'(iter) * PROD_BITS'(pal_inv_max);
    frac = ((prod >> NORM_DROP) > 65535) ? 16'hFFFF : prod[NORM_DROP +: 16];
    root = root_lut[frac[15 -: ROM_INDEX_BITS]];
    return {channel_level(root, pal_phase_r), channel_level(root, pal_phase_g),
            channel_level(root, pal_phase_b), 8'hFF};
  endfunction

  // Offer one pixel word; called and left on a rising edge
  task automatic feed_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic [ITER_BITS-1:0] iter, input logic key,
                            input logic typed, input logic [COLOR_BITS-1:0] typed_color);
    pixel_expect_t want;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_TDATA_BITS'({iter, y, x});
    s_axis_tuser_i  <= key;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    // advance the cycling accumulator before the color is formed
    if (key) begin
      turn_acc = turn_acc + SHIFT_STEP;
      if (turn_acc > SHIFT_TURN) turn_acc = '0;
    end
    want.x = x;
    want.y = y;
    want.color = typed ? typed_color : shade_pixel(iter);
    color_expect_q.push_back(want);
  endtask

  task automatic reg_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_ITER_LIMIT:  pal_iter_limit = value[ITER_BITS-1:0];
      REG_INV_MAX:     pal_inv_max    = value[INV_BITS-1:0];
      REG_INTERIOR:    pal_interior   = value;
      REG_PHASE_RED:   pal_phase_r    = value[PHASE_BITS-1:0];
      REG_PHASE_GREEN: pal_phase_g    = value[PHASE_BITS-1:0];
      REG_PHASE_BLUE:  pal_phase_b    = value[PHASE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_palette(input logic [31:0] iter_limit, input logic [31:0] inv_max,
                              input logic [31:0] interior, input logic [31:0] red,
                              input logic [31:0] green, input logic [31:0] blue);
    reg_write(REG_ITER_LIMIT, iter_limit);
    reg_write(REG_INV_MAX, inv_max);
    reg_write(REG_INTERIOR, interior);
    reg_write(REG_PHASE_RED, red);
    reg_write(REG_PHASE_GREEN, green);
    reg_write(REG_PHASE_BLUE, blue);
  endtask

  // Wait for every expected word, then let the pipeline settle
  task automatic drain_pixels();
    while (color_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    out_word_t     got;
    pixel_expect_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = out_word_t'(m_axis_tdata_o);
      if (color_expect_q.size() == 0) begin
        $error("output word with nothing expected: x %0h y %0h color %08h",
               got.x, got.y, got.color);
        mismatch_count++;
      end else begin
        want = color_expect_q.pop_front();
        if (got.x !== want.x) begin
          $error("out_x expected %0h got %0h", want.x, got.x);
          mismatch_count++;
        end
        if (got.y !== want.y) begin
          $error("out_y expected %0h got %0h", want.y, got.y);
          mismatch_count++;
        end
        if (got.color !== want.color) begin
          $error("pixel_color expected %08h got %08h", want.color, got.color);
          mismatch_count++;
        end
      end
    end
  end

  // Count cycles with no word moving on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [ITER_BITS-1:0] iter;
    logic [ITER_BITS-1:0] limit;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_rows[i]) begin
      feed_pixel(probe_rows[i].x, probe_rows[i].y, probe_rows[i].iter, probe_rows[i].key,
                 probe_rows[i].typed, probe_rows[i].color);
    end
    s_axis_tvalid_i <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain_pixels();
      case (p)
        1: load_palette(32'd1, 32'd0, 32'h0, 32'h0, 32'h0, 32'h0);  // zero reciprocal
        2: load_palette(32'hFFFF, 32'h100_0000, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF);
        3: begin
          limit = 16'($urandom_range(2, 4000));
          load_palette(32'(limit), 32'h100_0000 / 32'(limit), $urandom,
                       $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
        end
        4: load_palette($urandom_range(1, 65535), $urandom_range(32'h1FF_FFFF), $urandom,
                        $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
        5: load_palette(32'd0, 32'h1FF_FFFF, $urandom, $urandom_range(65535),
                        $urandom_range(65535), $urandom_range(65535));
        default: ;
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) begin
        case ($urandom_range(7))
          0: iter = pal_iter_limit;
          1: iter = pal_iter_limit + 16'd1;
          2: iter = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          3: iter = 16'($urandom);
          default: iter = 16'($urandom_range(pal_iter_limit));
        endcase
        feed_pixel(12'($urandom), 12'($urandom), iter, 1'($urandom), 1'b0, '0);
      end
      s_axis_tvalid_i <= 1'b0;
    end

    drain_pixels();
    if (mismatch_count == 0 && color_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
